// ----- hw/rtl/sepm_pkg.sv -----
// shared constants, codes and coil table of the stepper position move controller
package sepm_pkg;

    localparam int POSITION_BITS_DEF = 8;
    localparam int PHASE_COUNT       = 4;
    localparam int PHASE_BITS        = $clog2(PHASE_COUNT);

    localparam logic [7:0] HOME_DELAY_RESET = 8'd15;

    typedef enum logic [1:0] {
        MODE_TICK = 2'd0,
        MODE_MOVE = 2'd1,
        MODE_HOME = 2'd2
    } t_mode;

    localparam int  PADDR_BITS       = 3;
    localparam int  PDATA_BITS       = 32;
    localparam logic REG_HOME_DELAY  = 1'b0;

    localparam logic [3:0] COIL_A   = 4'h8;
    localparam logic [3:0] COIL_B   = 4'h4;
    localparam logic [3:0] COIL_C   = 4'h2;
    localparam logic [3:0] COIL_D   = 4'h1;
    localparam logic [3:0] COIL_OFF = 4'h0;

    // one-hot coil drive, negative direction plays the table backwards
    function automatic logic [3:0] coil_of(input logic [PHASE_BITS-1:0] phase,
                                           input logic neg);
        logic [PHASE_BITS-1:0] idx;
        idx = neg ? ~phase : phase;
        case (idx)
            2'd0:    coil_of = COIL_A;
            2'd1:    coil_of = COIL_B;
            2'd2:    coil_of = COIL_C;
            2'd3:    coil_of = COIL_D;
            default: coil_of = COIL_OFF;
        endcase
    endfunction

endpackage

// ----- hw/rtl/stepper_encoder_position_move.sv -----
// single-axis stepper move controller with encoder feedback and homing
//
// Each request is a one-millisecond tick (mode 0), a move command (mode 1) or a
// home command (mode 2); every request gives exactly one result. A move command
// taken while idle sets the direction and the number of encoder marks to pass
// from the difference between target_position and the current position. On ticks
// the coils step through the four one-hot phases 8,4,2,1 (1,2,4,8 when moving
// negative), each held for step_delay ticks (0 counts as 1). At each cycle start
// a move ends with the coils off once remaining is zero; otherwise a newly seen
// low encoder level moves the position by one and counts remaining down. Homing
// steps negative with the home_step_delay register as phase time until the limit
// switch reads low at a cycle start, and on the following cycle start zeroes the
// position. Commands arriving while busy, and mode 3, change nothing. Throughput
// is one request per clock unless i_out_stall holds a result; each request passes
// the input register, then the result register, with the whole state update done
// in a single pass of logic between them. The result register frees the input
// side while a result waits on o_out_valid/i_out_stall. home_step_delay sits at
// byte address 0 and should only be written while the controller is idle.
module stepper_encoder_position_move #(
    parameter int POSITION_BITS = sepm_pkg::POSITION_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // request channel
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic [1:0]                      i_mode,
    input  logic [7:0]                      i_target_position,
    input  logic [7:0]                      i_step_delay,
    input  logic                            i_encoder_level,
    input  logic                            i_limit_level,
    // result channel
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic [3:0]                      o_coil_pattern,
    output logic [7:0]                      o_position,
    output logic [7:0]                      o_remaining,
    output logic                            o_moving_negative,
    output logic                            o_busy_res,
    output logic                            o_done_res,
    // register port
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [sepm_pkg::PADDR_BITS-1:0] paddr,
    input  logic [sepm_pkg::PDATA_BITS-1:0] pwdata,
    output logic [sepm_pkg::PDATA_BITS-1:0] prdata,
    output logic                            pready
);
    import sepm_pkg::*;

    typedef enum logic [1:0] {
        ACT_IDLE = 2'd0,
        ACT_MOVE = 2'd1,
        ACT_HOME = 2'd2
    } t_activity;

    // register file
    logic [7:0] r_home_delay;

    // input register
    logic       r_in_valid;
    logic [1:0] r_mode;
    logic [7:0] r_target;
    logic [7:0] r_sdelay;
    logic       r_enc_level;
    logic       r_lim_level;

    // controller state
    logic [POSITION_BITS-1:0] r_position;
    logic [7:0]               r_remaining;
    logic                     r_negative;
    logic                     r_enc_seen;
    logic [PHASE_BITS-1:0]    r_phase;
    logic [7:0]               r_tick;
    logic [7:0]               r_active_delay;
    t_activity                r_activity;
    logic                     r_home_found;

    // result register
    logic       r_out_valid;
    logic [3:0] r_coil;
    logic [7:0] r_pos_out;
    logic [7:0] r_rem_out;
    logic       r_neg_out;
    logic       r_busy_out;
    logic       r_done_out;

    // next values
    logic [POSITION_BITS-1:0] n_position;
    logic [7:0]               n_remaining;
    logic                     n_negative;
    logic                     n_enc_seen;
    logic [PHASE_BITS-1:0]    n_phase;
    logic [7:0]               n_tick;
    logic [7:0]               n_active_delay;
    t_activity                n_activity;
    logic                     n_home_found;
    logic [3:0]               n_coil;
    logic                     n_done;

    logic                     w_cfg_wr;
    logic                     w_out_free;
    logic                     w_proc;
    logic                     w_in_take;
    logic [POSITION_BITS-1:0] w_target;
    logic [POSITION_BITS-1:0] w_diff;
    logic                     w_enc_low;
    logic                     w_lim_low;
    logic                     w_cycle_start;
    logic [7:0]               w_tick_inc;
    logic [PHASE_BITS-1:0]    w_coil_phase;

    // register port, zero wait states
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_HOME_DELAY);
    assign prdata   = (paddr[2] == REG_HOME_DELAY) ? PDATA_BITS'(r_home_delay) : '0;

    // handshake: the result register frees when empty or being taken
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_proc     = r_in_valid && w_out_free;
    assign o_in_stall = r_in_valid && !w_out_free;
    assign w_in_take  = i_in_valid && !o_in_stall;

    assign w_target  = POSITION_BITS'(r_target);
    assign w_enc_low = !r_enc_level;
    assign w_lim_low = !r_lim_level;
    assign w_diff    = (w_target < r_position) ? (r_position - w_target)
                                               : (w_target - r_position);
    assign w_cycle_start = (r_phase == '0) && (r_tick == 8'd0);
    assign w_tick_inc    = r_tick + 8'd1;

    // single-pass state update for the request in the input register
    always_comb begin
        n_position     = r_position;
        n_remaining    = r_remaining;
        n_negative     = r_negative;
        n_enc_seen     = r_enc_seen;
        n_phase        = r_phase;
        n_tick         = r_tick;
        n_active_delay = r_active_delay;
        n_activity     = r_activity;
        n_home_found   = r_home_found;
        n_done         = 1'b0;
        w_coil_phase   = r_phase;

        case (r_mode)
            MODE_TICK: begin
                if (r_activity != ACT_IDLE) begin
                    if (w_cycle_start) begin
                        case (r_activity)
                            ACT_MOVE: begin
                                if (r_remaining == 8'd0) begin
                                    n_done = 1'b1;
                                end else if (w_enc_low) begin
                                    // count a mark only on its leading low level
                                    if (!r_enc_seen) begin
                                        n_position  = r_negative ? r_position - 1'b1
                                                                 : r_position + 1'b1;
                                        n_remaining = r_remaining - 8'd1;
                                        n_enc_seen  = 1'b1;
                                    end
                                end else begin
                                    n_enc_seen = 1'b0;
                                end
                            end
                            ACT_HOME: begin
                                if (r_home_found) begin
                                    n_done     = 1'b1;
                                    n_position = '0;
                                    if (w_enc_low) begin
                                        n_enc_seen = 1'b1;
                                    end
                                end else if (w_lim_low) begin
                                    n_home_found = 1'b1;
                                end
                            end
                            default: begin
                            end
                        endcase
                    end
                    if (n_done) begin
                        n_activity = ACT_IDLE;
                        n_phase    = '0;
                        n_tick     = 8'd0;
                    end else if (w_tick_inc >= r_active_delay) begin
                        n_tick  = 8'd0;
                        n_phase = r_phase + 1'b1;
                    end else begin
                        n_tick = w_tick_inc;
                    end
                end
            end
            MODE_MOVE: begin
                if (r_activity == ACT_IDLE) begin
                    n_negative     = (w_target < r_position);
                    // wide positions saturate the mark count
                    n_remaining    = (w_diff > POSITION_BITS'(255)) ? 8'd255 : 8'(w_diff);
                    n_active_delay = (r_sdelay == 8'd0) ? 8'd1 : r_sdelay;
                    n_phase        = '0;
                    n_tick         = 8'd0;
                    n_activity     = ACT_MOVE;
                end
                w_coil_phase = n_phase;
            end
            MODE_HOME: begin
                if (r_activity == ACT_IDLE) begin
                    n_negative     = 1'b1;
                    n_remaining    = 8'd0;
                    n_home_found   = 1'b0;
                    n_active_delay = (r_home_delay == 8'd0) ? 8'd1 : r_home_delay;
                    n_phase        = '0;
                    n_tick         = 8'd0;
                    n_activity     = ACT_HOME;
                end
                w_coil_phase = n_phase;
            end
            default: begin
            end
        endcase

        // coils off when idle, including the tick that ends a move
        n_coil = (n_activity == ACT_IDLE) ? COIL_OFF : coil_of(w_coil_phase, n_negative);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_home_delay   <= HOME_DELAY_RESET;
            r_in_valid     <= 1'b0;
            r_out_valid    <= 1'b0;
            r_position     <= '0;
            r_remaining    <= 8'd0;
            r_negative     <= 1'b0;
            r_enc_seen     <= 1'b0;
            r_phase        <= '0;
            r_tick         <= 8'd0;
            r_active_delay <= 8'd1;
            r_activity     <= ACT_IDLE;
            r_home_found   <= 1'b0;
        end else begin
            if (w_cfg_wr) begin
                r_home_delay <= pwdata[7:0];
            end

            if (w_in_take) begin
                r_in_valid <= 1'b1;
            end else if (w_proc) begin
                r_in_valid <= 1'b0;
            end

            if (w_proc) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end

            if (w_proc) begin
                r_position     <= n_position;
                r_remaining    <= n_remaining;
                r_negative     <= n_negative;
                r_enc_seen     <= n_enc_seen;
                r_phase        <= n_phase;
                r_tick         <= n_tick;
                r_active_delay <= n_active_delay;
                r_activity     <= n_activity;
                r_home_found   <= n_home_found;
            end
        end

        // payload registers
        if (w_in_take) begin
            r_mode      <= i_mode;
            r_target    <= i_target_position;
            r_sdelay    <= i_step_delay;
            r_enc_level <= i_encoder_level;
            r_lim_level <= i_limit_level;
        end
        if (w_proc) begin
            r_coil     <= n_coil;
            r_pos_out  <= 8'(n_position);
            r_rem_out  <= n_remaining;
            r_neg_out  <= n_negative;
            r_busy_out <= (n_activity != ACT_IDLE);
            r_done_out <= n_done;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_coil_pattern    = r_coil;
    assign o_position        = r_pos_out;
    assign o_remaining       = r_rem_out;
    assign o_moving_negative = r_neg_out;
    assign o_busy_res        = r_busy_out;
    assign o_done_res        = r_done_out;

    // checks

    a_coil_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> $onehot0(o_coil_pattern))
        else $error("coil drive has more than one phase on");

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_done_res) |-> (!o_busy_res && o_coil_pattern == COIL_OFF))
        else $error("end of move reported while still driving");

    a_idle_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_activity == ACT_IDLE) |-> (r_phase == '0 && r_tick == 8'd0))
        else $error("phase counters not parked while idle");

    a_delay_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_active_delay != 8'd0)
        else $error("active phase delay is zero");

endmodule
